### rtl/itmh_pkg.sv
// ----------------------------------------------------------------------------
// Indexed timer min-heap package
// Shared types, codes and the key compare helper function of the timer heap core.
// ----------------------------------------------------------------------------
`default_nettype none
package itmh_pkg;

	localparam int HANDLE_W = 10;
	localparam int HANDLES  = 1 << HANDLE_W;
	localparam int KEY_W    = 32;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam logic [KEY_W-1:0] KEY_BUMP_RESET = 32'd86400000;

	localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
	localparam logic [OP_W-1:0] OP_POP      = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
	localparam logic [OP_W-1:0] OP_POSTPONE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_HANDLE = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_GOT,
		S_LAST,
		S_LIFT,
		S_LIFT_CMP,
		S_SINK,
		S_SINK_A,
		S_SINK_B,
		S_SINK_C,
		S_DONE
	} itmh_state_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ACCEPT,
		CMD_LOOK,
		CMD_INS,
		CMD_DUP,
		CMD_FULL,
		CMD_EMPTY,
		CMD_ABSENT,
		CMD_TAKE,
		CMD_POST,
		CMD_LAST,
		CMD_LIFT_RD,
		CMD_LIFT_MOVE,
		CMD_SINK_RD,
		CMD_SINK_A,
		CMD_SINK_B,
		CMD_SINK_MOVE,
		CMD_FINAL,
		CMD_OUT
	} itmh_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            present;
		logic            full;
		logic            empty;
		logic            p_is_last;
		logic            p_gt1;
		logic            c_gt_count;
		logic            c1_le_count;
		logic            later_parent;
		logic            later_child;
		logic            clr_done;
		logic            out_busy;
	} itmh_stat_t;

	// A key is later than another when their wrapped difference is positive.
	function automatic logic is_later(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic [KEY_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[KEY_W-1];
	endfunction

endpackage
`default_nettype wire

### rtl/itmh_in_if.sv
// ----------------------------------------------------------------------------
// Timer heap request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
`default_nettype none
interface itmh_in_if;
	import itmh_pkg::*;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [HANDLE_W-1:0] handle;
	logic [KEY_W-1:0]    key;
	modport source (output valid, output op, output handle, output key, input ready);
	modport sink (input valid, input op, input handle, input key, output ready);
endinterface
`default_nettype wire

### rtl/itmh_out_if.sv
// ----------------------------------------------------------------------------
// Timer heap result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface itmh_out_if #(
	parameter int TOTAL_W = 11
);
	import itmh_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] out_handle;
	logic [KEY_W-1:0]    out_key;
	logic [TOTAL_W-1:0]  entry_total;
	modport source (output valid, output status, output out_handle, output out_key,
		output entry_total, input ready);
	modport sink (input valid, input status, input out_handle, input out_key,
		input entry_total, output ready);
endinterface
`default_nettype wire

### rtl/itmh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module itmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/itmh_ctrl.sv
// ----------------------------------------------------------------------------
// Timer heap controller
// Sequences lookup, removal, lift and sink steps of each operation.
// ----------------------------------------------------------------------------
`default_nettype none
module itmh_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire itmh_pkg::itmh_stat_t stat,
	output      itmh_pkg::itmh_cmd_t  cmd
);
	import itmh_pkg::*;

	itmh_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_LOOK;
			end
			S_LOOK: state_d = S_GOT;
			S_GOT: begin
				state_d = S_DONE;
				case (stat.op)
					OP_INSERT: begin
						if (!stat.present && !stat.full) state_d = S_LIFT;
					end
					OP_POP: begin
						if (!stat.empty && !stat.p_is_last) state_d = S_LAST;
					end
					OP_REMOVE: begin
						if (stat.present && !stat.p_is_last) state_d = S_LAST;
					end
					OP_POSTPONE: begin
						if (stat.present) state_d = S_LIFT;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_LAST: state_d = S_LIFT;
			S_LIFT: state_d = stat.p_gt1 ? S_LIFT_CMP : S_SINK;
			S_LIFT_CMP: state_d = stat.later_parent ? S_LIFT : S_SINK;
			S_SINK: state_d = (cmd == CMD_FINAL) ? S_DONE : S_SINK_A;
			S_SINK_A: state_d = stat.c1_le_count ? S_SINK_B : S_SINK_C;
			S_SINK_B: state_d = S_SINK_C;
			S_SINK_C: state_d = stat.later_child ? S_SINK : S_DONE;
			S_DONE: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd = CMD_CLEAR;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd = CMD_ACCEPT;
			end
			S_LOOK: cmd = CMD_LOOK;
			S_GOT: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.present) cmd = CMD_DUP;
						else if (stat.full) cmd = CMD_FULL;
						else cmd = CMD_INS;
					end
					OP_POP: cmd = stat.empty ? CMD_EMPTY : CMD_TAKE;
					OP_REMOVE: cmd = stat.present ? CMD_TAKE : CMD_ABSENT;
					OP_POSTPONE: cmd = stat.present ? CMD_POST : CMD_ABSENT;
					default: cmd = CMD_NONE;
				endcase
			end
			S_LAST: cmd = CMD_LAST;
			S_LIFT: cmd = stat.p_gt1 ? CMD_LIFT_RD : CMD_NONE;
			S_LIFT_CMP: cmd = stat.later_parent ? CMD_LIFT_MOVE : CMD_NONE;
			S_SINK: cmd = stat.c_gt_count ? CMD_FINAL : CMD_SINK_RD;
			S_SINK_A: cmd = CMD_SINK_A;
			S_SINK_B: cmd = CMD_SINK_B;
			S_SINK_C: cmd = stat.later_child ? CMD_SINK_MOVE : CMD_FINAL;
			S_DONE: cmd = stat.out_busy ? CMD_NONE : CMD_OUT;
			default: cmd = CMD_NONE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/itmh_dp.sv
// ----------------------------------------------------------------------------
// Timer heap datapath
// Heap slot memories, position table, work registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module itmh_dp #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire itmh_pkg::itmh_cmd_t               cmd,
	output      itmh_pkg::itmh_stat_t              stat,
	input  wire logic [itmh_pkg::OP_W-1:0]         in_op,
	input  wire logic [itmh_pkg::HANDLE_W-1:0]     in_handle,
	input  wire logic [itmh_pkg::KEY_W-1:0]        in_key,
	input  wire logic                              cfg_we,
	input  wire logic [itmh_pkg::KEY_W-1:0]        cfg_wdata,
	output      logic                              out_valid,
	input  wire logic                              out_ready,
	output      logic [itmh_pkg::STATUS_W-1:0]     out_status,
	output      logic [itmh_pkg::HANDLE_W-1:0]     out_handle,
	output      logic [itmh_pkg::KEY_W-1:0]        out_key,
	output      logic [$clog2(CAPACITY+1)-1:0]     out_total
);
	import itmh_pkg::*;

	localparam int SW    = $clog2(CAPACITY + 1);
	localparam int DEPTH = CAPACITY + 1;
	localparam logic [SW-1:0] CAP_V = SW'(CAPACITY);
	localparam logic [SW-1:0] ROOT  = SW'(1);

	logic [OP_W-1:0]     op_q;
	logic [HANDLE_W-1:0] hin_q, h_q, ch_q, oh_q, out_handle_q;
	logic [KEY_W-1:0]    kin_q, k_q, ck_q, okey_q, bump_q, out_key_q;
	logic [SW-1:0]       p_q, c_q, count_q, out_total_q;
	logic                sinkm_q, out_valid_q;
	logic [HANDLE_W-1:0] clr_q;
	logic [STATUS_W-1:0] status_q, out_status_q;

	logic [SW-1:0]       pos_rd;
	logic [KEY_W-1:0]    sk_rd;
	logic [HANDLE_W-1:0] sh_rd;

	logic                pos_we;
	logic [HANDLE_W-1:0] pos_waddr;
	logic [SW-1:0]       pos_wdata;
	logic                slot_we;
	logic [SW-1:0]       slot_raddr;
	logic [KEY_W-1:0]    slot_wkey;
	logic [HANDLE_W-1:0] slot_whandle;

	logic [SW:0] c_full, c_next;

	assign c_full = {p_q, 1'b0};
	assign c_next = c_full + (SW+1)'(1);

	itmh_ram #(.WIDTH(SW), .DEPTH(HANDLES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(in_handle), .rdata(pos_rd)
	);

	itmh_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
		.clk(clk), .we(slot_we), .waddr(p_q), .wdata(slot_wkey),
		.raddr(slot_raddr), .rdata(sk_rd)
	);

	itmh_ram #(.WIDTH(HANDLE_W), .DEPTH(DEPTH)) u_handle_ram (
		.clk(clk), .we(slot_we), .waddr(p_q), .wdata(slot_whandle),
		.raddr(slot_raddr), .rdata(sh_rd)
	);

	always_comb begin
		pos_we       = 1'b0;
		pos_waddr    = h_q;
		pos_wdata    = p_q;
		slot_we      = 1'b0;
		slot_raddr   = count_q;
		slot_wkey    = k_q;
		slot_whandle = h_q;
		case (cmd)
			CMD_CLEAR: begin
				pos_we    = 1'b1;
				pos_waddr = clr_q;
				pos_wdata = '0;
			end
			CMD_LOOK: slot_raddr = (op_q == OP_POP) ? ROOT : pos_rd;
			CMD_TAKE: begin
				pos_we    = 1'b1;
				pos_waddr = sh_rd;
				pos_wdata = '0;
			end
			CMD_LIFT_RD: slot_raddr = p_q >> 1;
			CMD_LIFT_MOVE: begin
				pos_we       = 1'b1;
				pos_waddr    = sh_rd;
				slot_we      = 1'b1;
				slot_wkey    = sk_rd;
				slot_whandle = sh_rd;
			end
			CMD_SINK_RD: slot_raddr = c_full[SW-1:0];
			CMD_SINK_A: slot_raddr = c_next[SW-1:0];
			CMD_SINK_MOVE: begin
				pos_we       = 1'b1;
				pos_waddr    = ch_q;
				slot_we      = 1'b1;
				slot_wkey    = ck_q;
				slot_whandle = ch_q;
			end
			CMD_FINAL: begin
				pos_we  = 1'b1;
				slot_we = 1'b1;
			end
			default: slot_raddr = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			bump_q      <= KEY_BUMP_RESET;
		end else begin
			if (cfg_we) bump_q <= cfg_wdata;
			if (cmd == CMD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_CLEAR: clr_q <= clr_q + HANDLE_W'(1);
				CMD_INS: count_q <= count_q + SW'(1);
				CMD_TAKE: count_q <= count_q - SW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_ACCEPT: begin
				op_q  <= in_op;
				hin_q <= in_handle;
				kin_q <= in_key;
				oh_q  <= in_handle;
			end
			CMD_LOOK: p_q <= (op_q == OP_POP) ? ROOT : pos_rd;
			CMD_INS: begin
				p_q      <= count_q + SW'(1);
				k_q      <= kin_q;
				h_q      <= hin_q;
				sinkm_q  <= 1'b0;
				status_q <= ST_OK;
				okey_q   <= kin_q;
			end
			CMD_DUP: begin
				status_q <= ST_HANDLE;
				okey_q   <= sk_rd;
			end
			CMD_FULL: begin
				status_q <= ST_FULL;
				okey_q   <= kin_q;
			end
			CMD_EMPTY: begin
				status_q <= ST_EMPTY;
				okey_q   <= '0;
			end
			CMD_ABSENT: begin
				status_q <= ST_HANDLE;
				okey_q   <= '0;
			end
			CMD_TAKE: begin
				status_q <= ST_OK;
				oh_q     <= sh_rd;
				okey_q   <= sk_rd;
				sinkm_q  <= 1'b1;
			end
			CMD_POST: begin
				status_q <= ST_OK;
				k_q      <= sk_rd + bump_q;
				h_q      <= sh_rd;
				okey_q   <= sk_rd + bump_q;
				sinkm_q  <= 1'b1;
			end
			CMD_LAST: begin
				k_q <= sk_rd;
				h_q <= sh_rd;
			end
			CMD_LIFT_MOVE: p_q <= p_q >> 1;
			CMD_SINK_A: begin
				ck_q <= sk_rd;
				ch_q <= sh_rd;
				c_q  <= c_full[SW-1:0];
			end
			CMD_SINK_B: begin
				if (is_later(ck_q, sk_rd)) begin
					ck_q <= sk_rd;
					ch_q <= sh_rd;
					c_q  <= c_q + SW'(1);
				end
			end
			CMD_SINK_MOVE: p_q <= c_q;
			CMD_OUT: begin
				out_status_q <= status_q;
				out_handle_q <= oh_q;
				out_key_q    <= okey_q;
				out_total_q  <= count_q;
			end
			default: p_q <= p_q;
		endcase
	end

	always_comb begin
		stat.op           = op_q;
		stat.present      = (p_q != '0) && (p_q <= count_q);
		stat.full         = (count_q == CAP_V);
		stat.empty        = (count_q == '0);
		stat.p_is_last    = (p_q == count_q);
		stat.p_gt1        = (p_q > ROOT);
		stat.c_gt_count   = !sinkm_q || (c_full > {1'b0, count_q});
		stat.c1_le_count  = (c_next <= {1'b0, count_q});
		stat.later_parent = is_later(sk_rd, k_q);
		stat.later_child  = is_later(k_q, ck_q);
		stat.clr_done     = (clr_q == '1);
		stat.out_busy     = out_valid_q && !out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_handle = out_handle_q;
	assign out_key    = out_key_q;
	assign out_total  = out_total_q;
endmodule
`default_nettype wire

### rtl/indexed_timer_min_heap_core.sv
// ----------------------------------------------------------------------------
// Indexed timer min-heap core
// Binary min-heap of timed entries with a handle-to-slot position table.
//
// Requests arrive on in_ch (op, handle, key) and each produces exactly one
// item on out_ch (status, out_handle, out_key, entry_total). Operations are
// insert, pop earliest, remove by handle and postpone by cfg key bump.
// Keys compare by signed 32-bit difference, so they may wrap.
// One item is processed at a time. An entry that an item places climbs and
// then descends the heap level by level as far as it must; the single read
// port of the slot memories sets the per-level cost.
// The result sits in an output register; a stalled receiver holds the core
// in its done state until that register frees, and it takes the next item
// afterwards. After reset the position table is cleared entry by entry,
// during which in_ch is not ready; cfg writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_timer_min_heap_core #(
	parameter int CAPACITY = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	itmh_in_if.sink                         in_ch,
	itmh_out_if.source                      out_ch,
	input  wire logic                       cfg_we,
	input  wire logic [itmh_pkg::KEY_W-1:0] cfg_wdata
);
	import itmh_pkg::*;

	itmh_cmd_t  cmd;
	itmh_stat_t stat;

	itmh_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	itmh_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_op(in_ch.op), .in_handle(in_ch.handle), .in_key(in_ch.key),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_status(out_ch.status), .out_handle(out_ch.out_handle),
		.out_key(out_ch.out_key), .out_total(out_ch.entry_total)
	);
endmodule
`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// Timer heap core testbench
// Drives insert, pop, remove and postpone items into the indexed timer heap.
// A scoreboard keeps its own heap and position table to predict each result,
// then compares every field. The key bump is changed between phases, and
// random idling and one long receiver hold-off stress the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import itmh_pkg::*;

	class heap_scoreboard;
		typedef struct packed {
			logic [STATUS_W-1:0] status;
			logic [HANDLE_W-1:0] hnd;
			logic [KEY_W-1:0]    key;
			logic [10:0]         total;
		} heap_result_t;

		logic [KEY_W-1:0]    slot_key [1:1024];
		logic [HANDLE_W-1:0] slot_hnd [1:1024];
		int unsigned         slot_at [0:1023];
		int unsigned         live;
		logic [KEY_W-1:0]    bump;
		heap_result_t        pending [$];
		int                  errors;
		int                  checked;

		function new();
			foreach (slot_at[i]) slot_at[i] = 0;
			live = 0;
			bump = KEY_BUMP_RESET;
			errors = 0;
			checked = 0;
		endfunction

		function bit later(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
			logic [KEY_W-1:0] d;
			d = a - b;
			return (d != '0) && !d[KEY_W-1];
		endfunction

		function void place(int unsigned p, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
			slot_key[p] = k;
			slot_hnd[p] = h;
			slot_at[h] = p;
		endfunction

		function int unsigned climb(int unsigned p);
			logic [KEY_W-1:0]    k;
			logic [HANDLE_W-1:0] h;
			k = slot_key[p];
			h = slot_hnd[p];
			while (p > 1 && later(slot_key[p/2], k)) begin
				place(p, slot_key[p/2], slot_hnd[p/2]);
				p = p / 2;
			end
			place(p, k, h);
			return p;
		endfunction

		function void descend(int unsigned p);
			logic [KEY_W-1:0]    k;
			logic [HANDLE_W-1:0] h;
			int unsigned         c;
			k = slot_key[p];
			h = slot_hnd[p];
			forever begin
				c = p * 2;
				if (c > live) break;
				if (c + 1 <= live && later(slot_key[c], slot_key[c+1])) c++;
				if (!later(k, slot_key[c])) break;
				place(p, slot_key[c], slot_hnd[c]);
				p = c;
			end
			place(p, k, h);
		endfunction

		function void detach(int unsigned p);
			int unsigned last;
			last = live;
			slot_at[slot_hnd[p]] = 0;
			live--;
			if (p != last) begin
				place(p, slot_key[last], slot_hnd[last]);
				descend(climb(p));
			end
		endfunction

		function logic [HANDLE_W-1:0] pick_live();
			return slot_hnd[$urandom_range(1, live)];
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
			logic [KEY_W-1:0] k);
			heap_result_t r;
			int unsigned  p;
			bit           present;
			p = slot_at[h];
			present = (p != 0) && (p <= live);
			r.status = ST_OK;
			r.hnd = h;
			r.key = '0;
			if (op == OP_INSERT) begin
				if (present) begin
					r.status = ST_HANDLE;
					r.key = slot_key[p];
				end else if (live >= 1024) begin
					r.status = ST_FULL;
					r.key = k;
				end else begin
					live++;
					place(live, k, h);
					void'(climb(live));
					r.key = k;
				end
			end else if (op == OP_POP) begin
				if (live == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.hnd = slot_hnd[1];
					r.key = slot_key[1];
					detach(1);
				end
			end else if (!present) begin
				r.status = ST_HANDLE;
			end else if (op == OP_REMOVE) begin
				r.key = slot_key[p];
				detach(p);
			end else begin
				r.key = slot_key[p] + bump;
				slot_key[p] = r.key;
				descend(climb(p));
			end
			r.total = live[10:0];
			pending.push_back(r);
		endfunction

		function void check_result(heap_result_t got);
			heap_result_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			checked++;
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status,
					got.status);
				errors++;
			end
			if (got.hnd !== exp_r.hnd) begin
				$display("%0t: out_handle expected %0d actual %0d", $time, exp_r.hnd,
					got.hnd);
				errors++;
			end
			if (got.key !== exp_r.key) begin
				$display("%0t: out_key expected %h actual %h", $time, exp_r.key, got.key);
				errors++;
			end
			if (got.total !== exp_r.total) begin
				$display("%0t: entry_total expected %0d actual %0d", $time, exp_r.total,
					got.total);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [KEY_W-1:0] cfg_wdata;
	bit               idling;
	int               hold_req;
	int unsigned      cycles;
	logic [KEY_W-1:0] key_base;
	heap_scoreboard   sb;

	itmh_in_if  in_ch();
	itmh_out_if out_ch();

	indexed_timer_min_heap_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 800000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_item(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
		logic [KEY_W-1:0] k);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.handle <= h;
		in_ch.key <= k;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_request(op, h, k);
	endtask

	task automatic settle_and_write(logic [KEY_W-1:0] v);
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.bump = v;
		@(posedge clk);
	endtask

	task automatic random_item();
		int unsigned      r;
		logic [OP_W-1:0]  op;
		logic [HANDLE_W-1:0] h;
		logic [KEY_W-1:0] k;
		r = $urandom_range(0, 99);
		h = ($urandom_range(0, 4) != 0) ? HANDLE_W'($urandom_range(0, 63))
			: HANDLE_W'($urandom_range(0, 1023));
		case ($urandom_range(0, 9))
			0: k = $urandom();
			1: k = 32'hFFFF_FFFF;
			2: k = 32'h8000_0000;
			3: k = 32'h7FFF_FFFF;
			default: k = key_base + $urandom_range(0, 40);
		endcase
		if (r < 45) begin
			op = OP_INSERT;
		end else if (r < 65) begin
			op = OP_POP;
		end else begin
			op = (r < 85) ? OP_REMOVE : OP_POSTPONE;
			if (sb.live != 0 && $urandom_range(0, 4) != 0) h = sb.pick_live();
		end
		send_item(op, h, k);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result({out_ch.status, out_ch.out_handle, out_ch.out_key,
					out_ch.entry_total});
			if (hold_req > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold_req) @(posedge clk);
				hold_req = 0;
				out_ch.ready <= 1'b1;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [KEY_W-1:0] bumps [5];
		sb = new();
		idling = 1'b1;
		hold_req = 0;
		key_base = 32'h7FFF_FFF0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.op <= OP_INSERT;
		in_ch.handle <= '0;
		in_ch.key <= '0;
		out_ch.ready <= 1'b1;
		bumps = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, $urandom()};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_POP, 10'd1023, 32'h1234);
		send_item(OP_REMOVE, 10'd0, 32'd0);
		send_item(OP_POSTPONE, 10'd1023, 32'd0);
		send_item(OP_INSERT, 10'd0, 32'd0);
		send_item(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
		send_item(OP_INSERT, 10'd0, 32'd5);
		send_item(OP_INSERT, 10'd5, 32'h8000_0000);
		send_item(OP_INSERT, 10'd6, 32'h7FFF_FFFF);
		send_item(OP_INSERT, 10'd7, 32'd0);
		send_item(OP_INSERT, 10'd8, 32'd0);
		send_item(OP_POSTPONE, 10'd0, 32'd0);
		send_item(OP_REMOVE, 10'd5, 32'd0);
		send_item(OP_REMOVE, 10'd5, 32'd0);
		send_item(OP_POP, 10'd0, 32'd0);
		send_item(OP_POSTPONE, 10'd6, 32'd0);
		for (int i = 0; i < 6; i++) send_item(OP_POP, 10'd3, 32'd0);

		foreach (bumps[ph]) begin
			settle_and_write(bumps[ph]);
			if (ph == 4) idling = 1'b0;
			for (int i = 0; i < 220; i++) begin
				if (ph == 1 && i == 50) hold_req = 600;
				if ($urandom_range(0, 30) == 0) key_base = $urandom();
				random_item();
			end
		end
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("Checked %0d results over five key bump settings, including wrapped keys,",
			sb.checked);
		$display("ties, absent handles, an empty heap and a long output stall.");
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire
